>>> rtl/lpsi_pkg.sv
// shared constants, command and status types for the symbol index
`timescale 1ns / 1ps
`default_nettype none
package lpsi_pkg;

    localparam int SLOT_COUNT_DEF   = 8192;
    localparam int CODE_COUNT_DEF   = 4096;
    localparam int MAX_SYMBOL_BYTES = 16;
    localparam int CODE_W           = 12;
    localparam int LEN_W            = 5;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    // hash constants
    localparam logic [63:0] HASH_SEED  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_LEN_K = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
    localparam logic [63:0] HASH_MIX_K = 64'hbf58476d1ce4e5b9;

    // multiplier operand selection for the final hash multiply
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_LH = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       dec;
        logic       clr_step;
        logic       len_dec;
        logic       hash_init;
        logic       hash_lo;
        logic       hash_hi;
        logic       hash_mix;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       hash_fin;
        logic       slot_rd;
        logic       sym_rd;
        logic       probe_next;
        logic       ins_write;
        logic       set_match;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       ins_ok;
        logic       len_lt2;
        logic       len_present;
        logic       len_gt8;
        logic       slot_empty;
        logic       sym_hit;
        logic       probe_last;
        logic       clr_last;
        logic       out_busy;
    } stat_t;

    // keep the lowest n bytes of a word, zero the rest
    function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [LEN_W-1:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (LEN_W'(i) < n) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lpsi_ctrl.sv
// controller state machine sequencing clear, hash, probe and result steps
`timescale 1ns / 1ps
`default_nettype none
module lpsi_ctrl
    import lpsi_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [4:0] ST_BOOT  = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_DEC   = 5'd2;
    localparam logic [4:0] ST_CLR   = 5'd3;
    localparam logic [4:0] ST_LCHK  = 5'd4;
    localparam logic [4:0] ST_HINIT = 5'd5;
    localparam logic [4:0] ST_HLO   = 5'd6;
    localparam logic [4:0] ST_HHI   = 5'd7;
    localparam logic [4:0] ST_HMIX  = 5'd8;
    localparam logic [4:0] ST_MUL0  = 5'd9;
    localparam logic [4:0] ST_MUL1  = 5'd10;
    localparam logic [4:0] ST_MUL2  = 5'd11;
    localparam logic [4:0] ST_HFIN  = 5'd12;
    localparam logic [4:0] ST_PRD   = 5'd13;
    localparam logic [4:0] ST_PSW   = 5'd14;
    localparam logic [4:0] ST_PSY   = 5'd15;
    localparam logic [4:0] ST_WRITE = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       is_find;

    assign is_find = (stat.req == REQ_FIND);
    assign s_ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_BOOT: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.dec = 1'b1;
                priority if (stat.req == REQ_CLEAR) state_next = ST_CLR;
                else if (stat.req == REQ_INSERT) state_next = stat.ins_ok ? ST_HINIT : ST_DONE;
                else if (stat.req == REQ_FIND) state_next = ST_LCHK;
                else state_next = ST_DONE;
            end
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_DONE;
            end
            ST_LCHK: begin
                priority if (stat.len_lt2) state_next = ST_DONE;
                else if (!stat.len_present) cmd.len_dec = 1'b1;
                else state_next = ST_HINIT;
            end
            ST_HINIT: begin
                cmd.hash_init = 1'b1;
                state_next    = ST_HLO;
            end
            ST_HLO: begin
                cmd.hash_lo = 1'b1;
                state_next  = ST_HHI;
            end
            ST_HHI: begin
                cmd.hash_hi = stat.len_gt8;
                state_next  = ST_HMIX;
            end
            ST_HMIX: begin
                cmd.hash_mix = 1'b1;
                state_next   = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LL;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HL;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LH;
                state_next  = ST_HFIN;
            end
            ST_HFIN: begin
                cmd.hash_fin = 1'b1;
                state_next   = ST_PRD;
            end
            ST_PRD: begin
                cmd.slot_rd = 1'b1;
                state_next  = ST_PSW;
            end
            ST_PSW: begin
                if (stat.slot_empty) begin
                    if (is_find) begin
                        cmd.len_dec = 1'b1;
                        state_next  = ST_LCHK;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end else begin
                    cmd.sym_rd = 1'b1;
                    state_next = ST_PSY;
                end
            end
            ST_PSY: begin
                if (stat.sym_hit) begin
                    cmd.set_match = is_find;
                    state_next    = ST_DONE;
                end else begin
                    cmd.probe_next = 1'b1;
                    priority if (!stat.probe_last) state_next = ST_PRD;
                    else if (is_find) begin
                        cmd.len_dec = 1'b1;
                        state_next  = ST_LCHK;
                    end else state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                cmd.ins_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_BOOT;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/lpsi_datapath.sv
// datapath: request registers, hash unit, slot and symbol memories, result register
`timescale 1ns / 1ps
`default_nettype none
module lpsi_datapath
    import lpsi_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int CODE_COUNT = CODE_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [63:0] s_bytes_low,
    input  wire logic [63:0] s_bytes_high,
    input  wire logic [4:0]  s_byte_count,
    input  wire logic [11:0] s_sym_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_match_code,
    output logic             m_inserted
);

    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int CIW = $clog2(CODE_COUNT);
    localparam int SYM_W = 64 + 64 + LEN_W;

    // request registers
    logic [1:0]        req_reg;
    logic [63:0]       lo_in_reg, hi_in_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [CODE_W-1:0] code_reg;

    // working registers
    logic [LEN_W-1:0]  len_reg;
    logic [63:0]       hash_reg, acc_reg;
    logic [SW-1:0]     slot_idx_reg, probe_cnt_reg, clr_idx_reg;
    logic [CODE_W:0]   slot_q_reg;
    logic [SYM_W-1:0]  sym_q_reg;
    logic [16:0]       mask_reg;
    logic [LEN_W-1:0]  longest_reg;
    logic [CODE_W-1:0] match_reg;
    logic              added_reg;
    logic              m_valid_reg;
    logic [CODE_W-1:0] m_code_reg;
    logic              m_ins_reg;

    // memories
    logic [CODE_W:0]   slot_mem [SLOT_COUNT];
    logic [SYM_W-1:0]  sym_mem  [CODE_COUNT];

    logic [63:0]       key_lo, key_hi, x_lo, x_hi, mul_a32, mul_b32;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [LEN_W-1:0]  hi_len;

    // masked key at the current length
    assign key_lo = keep_bytes(lo_in_reg, len_reg);
    assign key_hi = (len_reg > LEN_W'(8)) ? keep_bytes(hi_in_reg, len_reg - LEN_W'(8)) : '0;
    assign x_lo   = hash_reg ^ key_lo;
    assign x_hi   = hash_reg ^ key_hi;

    // shared 32x32 multiplier for the final mix
    assign mul_a32 = (cmd.mul_sel == MUL_HL) ? {32'b0, hash_reg[63:32]} : {32'b0, hash_reg[31:0]};
    assign mul_b32 = (cmd.mul_sel == MUL_LH) ? {32'b0, HASH_MIX_K[63:32]}
                                             : {32'b0, HASH_MIX_K[31:0]};
    assign mul_a = mul_a32[31:0];
    assign mul_b = mul_b32[31:0];
    assign mul_p = mul_a * mul_b;

    // find starts at the longest usable length
    always_comb begin
        hi_len = count_reg;
        if (hi_len > LEN_W'(MAX_SYMBOL_BYTES)) hi_len = LEN_W'(MAX_SYMBOL_BYTES);
        if (hi_len > longest_reg) hi_len = longest_reg;
    end

    // status to the controller
    assign stat.req         = req_reg;
    assign stat.ins_ok      = (count_reg >= LEN_W'(1)) && (count_reg <= LEN_W'(MAX_SYMBOL_BYTES))
                              && (17'(code_reg) < 17'(CODE_COUNT));
    assign stat.len_lt2     = (len_reg < LEN_W'(2));
    assign stat.len_present = mask_reg[len_reg];
    assign stat.len_gt8     = (len_reg > LEN_W'(8));
    assign stat.slot_empty  = !slot_q_reg[CODE_W];
    assign stat.sym_hit     = (sym_q_reg == {key_lo, key_hi, len_reg});
    assign stat.probe_last  = (probe_cnt_reg == '1);
    assign stat.clr_last    = (clr_idx_reg == '1);
    assign stat.out_busy    = m_valid_reg && !m_ready;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lo_in_reg <= s_bytes_low;
            hi_in_reg <= s_bytes_high;
            count_reg <= s_byte_count;
            code_reg  <= s_sym_code;
        end
    end

    // request type, kept cleared so reset leaves no stale type
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= REQ_CLEAR;
        end else if (cmd.load_in) begin
            req_reg <= s_req_type;
        end
    end

    // length, hash and probe position
    always_ff @(posedge aclk) begin
        if (cmd.dec) begin
            len_reg <= (req_reg == REQ_FIND) ? hi_len : count_reg;
        end else if (cmd.len_dec) begin
            len_reg <= len_reg - LEN_W'(1);
        end
        if (cmd.hash_init) begin
            hash_reg <= HASH_SEED ^ (64'(len_reg) * HASH_LEN_K);
        end else if (cmd.hash_lo) begin
            hash_reg <= (x_lo << 40) + (x_lo * 64'h1b3);
        end else if (cmd.hash_hi) begin
            hash_reg <= (x_hi << 40) + (x_hi * 64'h1b3);
        end else if (cmd.hash_mix) begin
            hash_reg <= hash_reg ^ (hash_reg >> 29);
        end else if (cmd.hash_fin) begin
            hash_reg <= acc_reg ^ (acc_reg >> 32);
        end
        if (cmd.mul_en) begin
            if (cmd.mul_sel == MUL_LL) acc_reg <= mul_p;
            else acc_reg <= acc_reg + {mul_p[31:0], 32'b0};
        end
        if (cmd.hash_fin) begin
            slot_idx_reg  <= acc_reg[SW-1:0] ^ acc_reg[32 +: SW];
            probe_cnt_reg <= '0;
        end else if (cmd.probe_next) begin
            slot_idx_reg  <= slot_idx_reg + SW'(1);
            probe_cnt_reg <= probe_cnt_reg + SW'(1);
        end
    end

    // clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_idx_reg <= clr_idx_reg + SW'(1);
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            slot_mem[clr_idx_reg] <= '0;
        end else if (cmd.ins_write) begin
            slot_mem[slot_idx_reg] <= {1'b1, code_reg};
        end
        if (cmd.slot_rd) begin
            slot_q_reg <= slot_mem[slot_idx_reg];
        end
    end

    // symbol memory
    always_ff @(posedge aclk) begin
        if (cmd.ins_write) begin
            sym_mem[CIW'(code_reg)] <= {key_lo, key_hi, len_reg};
        end
        if (cmd.sym_rd) begin
            sym_q_reg <= sym_mem[CIW'(slot_q_reg[CODE_W-1:0])];
        end
    end

    // length mask and longest length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            longest_reg <= LEN_W'(1);
        end else if (cmd.dec && req_reg == REQ_CLEAR) begin
            mask_reg    <= '0;
            longest_reg <= LEN_W'(1);
        end else if (cmd.ins_write) begin
            mask_reg[len_reg] <= 1'b1;
            if (len_reg > longest_reg) longest_reg <= len_reg;
        end
    end

    // item result
    always_ff @(posedge aclk) begin
        if (cmd.dec) begin
            match_reg <= (req_reg == REQ_FIND) ? {4'b0, lo_in_reg[7:0]} : '0;
            added_reg <= 1'b0;
        end else if (cmd.set_match) begin
            match_reg <= slot_q_reg[CODE_W-1:0];
        end else if (cmd.ins_write) begin
            added_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_code_reg <= match_reg;
            m_ins_reg  <= added_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_match_code = m_code_reg;
    assign m_inserted   = m_ins_reg;

    // checks
    a_write_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_write |-> !slot_q_reg[CODE_W]) else $error("insert over occupied slot");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready)) else $error("result overwritten");
    a_added_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && added_reg) |-> (req_reg == REQ_INSERT)) else $error("stray insert flag");
    a_longest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (longest_reg >= LEN_W'(1)) && (longest_reg <= LEN_W'(MAX_SYMBOL_BYTES)))
        else $error("longest length out of range");

endmodule
`default_nettype wire

>>> rtl/longest_prefix_symbol_index.sv
// Top level: hashed symbol index with longest-prefix find, one item in flight at a time.
// Clear sweeps every slot; insert probes from the hashed slot until an empty slot or a hit,
// and an insert whose length or code is out of range is rejected without probing.
// Find hashes each present length from the longest usable one down, probes its chain of
// slots, and skips lengths that are not present.
// After reset a sweep empties the slot memory before the first item
// is accepted; the reset is synchronous and active low.
`timescale 1ns / 1ps
`default_nettype none
module longest_prefix_symbol_index
    import lpsi_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int CODE_COUNT = CODE_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [63:0] s_bytes_low,
    input  wire logic [63:0] s_bytes_high,
    input  wire logic [4:0]  s_byte_count,
    input  wire logic [11:0] s_sym_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_match_code,
    output logic             m_inserted
);

    cmd_t  cmd;
    stat_t stat;

    // controller
    lpsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    lpsi_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .CODE_COUNT (CODE_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_req_type   (s_req_type),
        .s_bytes_low  (s_bytes_low),
        .s_bytes_high (s_bytes_high),
        .s_byte_count (s_byte_count),
        .s_sym_code   (s_sym_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_match_code (m_match_code),
        .m_inserted   (m_inserted)
    );

endmodule
`default_nettype wire
